@@ design/ssjs_pkg.sv @@
// ssjs_pkg: shared types, codes and default sizes of the job scheduler.
// No dependencies; every other file of the block imports it.
package ssjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_SERVERS_DEF = 8;
  localparam int TIME_BITS_DEF   = 16;
  localparam int SLICE_BITS      = 16;

  localparam logic [1:0] REQ_ARRIVE   = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;

  localparam logic [2:0] EV_ACCEPTED = 3'd0;
  localparam logic [2:0] EV_REFUSED  = 3'd1;
  localparam logic [2:0] EV_FINISHED = 3'd2;
  localparam logic [2:0] EV_TICK     = 3'd3;
  localparam logic [2:0] EV_DISPATCH = 3'd4;

  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;

  localparam logic [1:0] CFG_POLICY   = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_QUANTUM  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK,
    ST_EMIT_FIN,
    ST_REQUEUE,
    ST_ADMIT,
    ST_EMIT
  } state_e;

endpackage

@@ design/ssjs_cell.sv @@
// ssjs_cell: one storage cell of a row; holds, loads, or takes a neighbor's word.
// Depends on ssjs_pkg.
module ssjs_cell #(
  parameter int W = 8
) (
  input  logic               clk_i,
  input  ssjs_pkg::cell_op_e op_i,
  input  logic [W-1:0]       load_i,
  input  logic [W-1:0]       left_i,
  input  logic [W-1:0]       right_i,
  output logic [W-1:0]       q_o
);
  import ssjs_pkg::*;

  logic [W-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      OP_HOLD:  data_d = data_q;
      OP_LOAD:  data_d = load_i;
      OP_LEFT:  data_d = left_i;
      OP_RIGHT: data_d = right_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

@@ design/ssjs_row.sv @@
// ssjs_row: row of cells that shifts toward the head and loads at an index.
// Depends on ssjs_pkg and ssjs_cell.
module ssjs_row #(
  parameter int N = 8,
  parameter int W = 8,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          load_i,
  input  logic [IW-1:0] load_idx_i,
  input  logic [W-1:0]  load_data_i,
  output logic [W-1:0]  head_o
);
  import ssjs_pkg::*;

  logic [W-1:0] cq    [N];
  logic [W-1:0] right [N];
  cell_op_e     op    [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_end
      assign right[i] = cq[i];
    end else begin : g_mid
      assign right[i] = cq[i+1];
    end

    always_comb begin
      if (load_i && load_idx_i == IW'(i)) begin
        op[i] = OP_LOAD;
      end else if (shift_i) begin
        op[i] = OP_RIGHT;
      end else begin
        op[i] = OP_HOLD;
      end
    end

    ssjs_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .op_i   (op[i]),
      .load_i (load_data_i),
      .left_i (cq[i]),
      .right_i(right[i]),
      .q_o    (cq[i])
    );
  end

  assign head_o = cq[0];

endmodule

@@ design/ssjs_wait_row.sv @@
// ssjs_wait_row: wait queue as a row of cells; ordered insert, pop at head.
// Depends on ssjs_pkg and ssjs_cell.
module ssjs_wait_row #(
  parameter int QD = 16,
  parameter int TB = 16,
  localparam int CW = $clog2(QD + 1),
  localparam int W  = 16 + TB
) (
  input  logic          clk_i,
  input  logic          prio_mode_i,
  input  logic [CW-1:0] count_i,
  input  logic          ins_i,
  input  logic          pop_i,
  input  logic [W-1:0]  ins_data_i,
  output logic [W-1:0]  head_o
);
  import ssjs_pkg::*;

  logic [W-1:0] cq    [QD];
  logic [W-1:0] left  [QD];
  logic [W-1:0] right [QD];
  cell_op_e     op    [QD];
  logic [QD-1:0] mark;
  logic [QD-1:0] ahead;
  logic [7:0]    ins_prio;

  assign ins_prio = ins_data_i[TB +: 8];

  for (genvar i = 0; i < QD; i++) begin : g_cell
    // insert point: first lower-priority entry (priority mode only), or the end of the queue
    assign mark[i] = (prio_mode_i && (CW'(i) < count_i) && (cq[i][TB +: 8] < ins_prio))
                     || (CW'(i) == count_i);

    if (i == 0) begin : g_head
      assign ahead[i] = 1'b0;
      assign left[i]  = cq[i];
    end else begin : g_body
      assign ahead[i] = ahead[i-1] | mark[i-1];
      assign left[i]  = cq[i-1];
    end

    if (i == QD - 1) begin : g_tail
      assign right[i] = cq[i];
    end else begin : g_nxt
      assign right[i] = cq[i+1];
    end

    always_comb begin
      if (ins_i) begin
        if (ahead[i]) begin
          op[i] = OP_LEFT;
        end else if (mark[i]) begin
          op[i] = OP_LOAD;
        end else begin
          op[i] = OP_HOLD;
        end
      end else if (pop_i) begin
        op[i] = OP_RIGHT;
      end else begin
        op[i] = OP_HOLD;
      end
    end

    ssjs_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .op_i   (op[i]),
      .load_i (ins_data_i),
      .left_i (left[i]),
      .right_i(right[i]),
      .q_o    (cq[i])
    );
  end

  assign head_o = cq[0];

endmodule

@@ design/service_station_job_scheduler_core.sv @@
// service_station_job_scheduler_core: wait queue, server row and held row of one
// service station. Depends on ssjs_pkg, ssjs_wait_row, ssjs_row, ssjs_cell.
//
// Usage: the slave stream carries requests (tuser = request kind: arrival,
// tick, dispatch; tdata = job id, priority, service time). The master stream
// returns result words, the last word of each request flagged by tlast.
// One request is worked on at a time; s_axis_tready is high only while idle.
// Work per request, after the accepting edge:
//   arrival  : one insertion step in the wait-queue cell row, skipped
//              when the arrival is refused.
//   tick     : one walk of the server row (one job a cycle), then one result
//              word per finished job and a closing tick word.
//   dispatch : held jobs are re-inserted while the wait queue has room, then
//              admitted jobs are moved, one per cycle, before the dispatch word.
// The next request can be taken in the cycle after the last word is loaded.
// Results leave through one output register; while the receiver stalls the
// block holds in its emit state and takes no new request.
// Reset empties all rows (counts to zero) and loads policy fifo, capacity 1,
// quantum 1. Configuration writes are taken in any cycle, with no handshake.
module service_station_job_scheduler_core #(
  parameter int QUEUE_DEPTH = ssjs_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVERS = ssjs_pkg::MAX_SERVERS_DEF,
  parameter int TIME_BITS   = ssjs_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // job_id, job_priority, service_time
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // done_id, idle, queued, in_service
  output logic [2:0]  m_axis_tuser,   // event_res
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import ssjs_pkg::*;

  localparam int WCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW = $clog2(MAX_SERVERS + 1);
  localparam int SIW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int JW  = 16 + TIME_BITS;
  localparam int SW  = JW + SLICE_BITS;
  localparam logic [WCW-1:0] WQ_FULL = WCW'(QUEUE_DEPTH);
  localparam logic [SCW-1:0] SRV_MAX = SCW'(MAX_SERVERS);

  state_e state_q, state_d;

  logic [1:0]  policy_q;
  logic [3:0]  capacity_q;
  logic [15:0] quantum_q;

  logic [WCW-1:0] wait_count_q, wait_count_d;
  logic [SCW-1:0] serve_count_q, serve_count_d;
  logic [SCW-1:0] held_count_q, held_count_d;
  logic [SCW-1:0] fin_cnt_q, fin_cnt_d;
  logic [SCW-1:0] steps_q, steps_d;
  logic           idle_q, idle_d;

  logic [7:0]           in_id_q, in_id_d;
  logic [7:0]           in_prio_q, in_prio_d;
  logic [TIME_BITS-1:0] in_time_q, in_time_d;
  logic [2:0]           emit_ev_q, emit_ev_d;
  logic [7:0]           emit_id_q, emit_id_d;

  logic       out_valid_q;
  logic [2:0] out_ev_q, out_ev_d;
  logic [7:0] out_id_q, out_id_d;
  logic       out_idle_q, out_idle_d;
  logic [4:0] out_queued_q;
  logic [3:0] out_insvc_q;
  logic       out_last_q, out_last_d;
  logic       out_load, out_free;

  logic          wq_ins, wq_pop, wq_src_held;
  logic [JW-1:0] wq_ins_data, wq_head;
  logic          srv_shift, srv_load;
  logic [SIW-1:0] srv_idx;
  logic [SW-1:0] srv_data, srv_head;
  logic          held_shift, held_load;
  logic [JW-1:0] held_head;
  logic          fin_shift, fin_load;
  logic [7:0]    fin_head;

  // input unpack
  logic [31:0]          t32;
  logic [TIME_BITS-1:0] t_in;
  logic [7:0]           a_id, a_prio;
  logic                 arr_full;

  assign a_id     = s_axis_tdata[7:0];
  assign a_prio   = s_axis_tdata[15:8];
  assign t32      = 32'(s_axis_tdata[31:16]);
  assign t_in     = (t32[TIME_BITS-1:0] == '0) ? TIME_BITS'(1) : t32[TIME_BITS-1:0];
  assign arr_full = (32'(wait_count_q) + 32'(held_count_q)) >= 32'(QUEUE_DEPTH);

  // head of server row during a tick
  logic [7:0]            h_id, h_prio;
  logic [TIME_BITS-1:0]  h_time, t1;
  logic [SLICE_BITS-1:0] h_slice, s_dec, s_keep;
  logic                  h_exp, h_fin, h_held, h_keep;

  assign h_slice = srv_head[SLICE_BITS-1:0];
  assign h_time  = srv_head[SLICE_BITS +: TIME_BITS];
  assign h_prio  = srv_head[SLICE_BITS+TIME_BITS +: 8];
  assign h_id    = srv_head[SLICE_BITS+TIME_BITS+8 +: 8];
  assign t1      = h_time - TIME_BITS'(1);
  assign s_dec   = (h_slice != '0) ? h_slice - SLICE_BITS'(1) : h_slice;
  assign h_exp   = (h_slice != '0) && (s_dec == '0);
  assign h_fin   = (t1 == '0);
  assign h_held  = !h_fin && h_exp && (held_count_q < SRV_MAX);
  assign h_keep  = !h_fin && !h_held;
  assign s_keep  = h_exp ? quantum_q : s_dec;

  logic [SCW-1:0] sc_m1;
  logic           cap_ok;
  assign sc_m1  = serve_count_q - SCW'(1);
  assign cap_ok = (32'(serve_count_q) < 32'(capacity_q)) && (serve_count_q < SRV_MAX);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign wq_ins_data   = wq_src_held ? held_head : {in_id_q, in_prio_q, in_time_q};

  always_comb begin
    state_d       = state_q;
    wait_count_d  = wait_count_q;
    serve_count_d = serve_count_q;
    held_count_d  = held_count_q;
    fin_cnt_d     = fin_cnt_q;
    steps_d       = steps_q;
    idle_d        = idle_q;
    in_id_d       = in_id_q;
    in_prio_d     = in_prio_q;
    in_time_d     = in_time_q;
    emit_ev_d     = emit_ev_q;
    emit_id_d     = emit_id_q;
    wq_ins        = 1'b0;
    wq_pop        = 1'b0;
    wq_src_held   = 1'b0;
    srv_shift     = 1'b0;
    srv_load      = 1'b0;
    srv_idx       = serve_count_q[SIW-1:0];
    srv_data      = {wq_head, ((policy_q == POL_RR) ? quantum_q : SLICE_BITS'(0))};
    held_shift    = 1'b0;
    held_load     = 1'b0;
    fin_shift     = 1'b0;
    fin_load      = 1'b0;
    out_load      = 1'b0;
    out_ev_d      = emit_ev_q;
    out_id_d      = emit_id_q;
    out_idle_d    = 1'b0;
    out_last_d    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_id_d   = a_id;
          in_prio_d = a_prio;
          in_time_d = t_in;
          case (s_axis_tuser)
            REQ_ARRIVE: begin
              if (arr_full) begin
                emit_ev_d = EV_REFUSED;
                emit_id_d = a_id;
                state_d   = ST_EMIT;
              end else begin
                state_d = ST_ARRIVE;
              end
            end
            REQ_TICK: begin
              steps_d   = serve_count_q;
              idle_d    = (serve_count_q == '0);
              fin_cnt_d = '0;
              state_d   = ST_TICK;
            end
            REQ_DISPATCH: state_d = ST_REQUEUE;
            default: ;
          endcase
        end
      end
      ST_ARRIVE: begin
        wq_ins       = 1'b1;
        wait_count_d = wait_count_q + WCW'(1);
        emit_ev_d    = EV_ACCEPTED;
        emit_id_d    = '0;
        state_d      = ST_EMIT;
      end
      ST_TICK: begin
        if (steps_q == '0) begin
          state_d = ST_EMIT_FIN;
        end else begin
          steps_d   = steps_q - SCW'(1);
          srv_shift = 1'b1;
          srv_load  = h_keep;
          srv_idx   = sc_m1[SIW-1:0];
          srv_data  = {h_id, h_prio, t1, s_keep};
          held_load = h_held;
          fin_load  = h_fin;
          if (!h_keep) serve_count_d = sc_m1;
          if (h_held) held_count_d = held_count_q + SCW'(1);
          if (h_fin) fin_cnt_d = fin_cnt_q + SCW'(1);
        end
      end
      ST_EMIT_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fin_cnt_q != '0) begin
            out_ev_d   = EV_FINISHED;
            out_id_d   = fin_head;
            out_last_d = 1'b0;
            fin_shift  = 1'b1;
            fin_cnt_d  = fin_cnt_q - SCW'(1);
          end else begin
            out_ev_d   = EV_TICK;
            out_id_d   = '0;
            out_idle_d = idle_q;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_REQUEUE: begin
        if (held_count_q != '0 && wait_count_q < WQ_FULL) begin
          wq_ins       = 1'b1;
          wq_src_held  = 1'b1;
          held_shift   = 1'b1;
          held_count_d = held_count_q - SCW'(1);
          wait_count_d = wait_count_q + WCW'(1);
        end else begin
          state_d = ST_ADMIT;
        end
      end
      ST_ADMIT: begin
        if (wait_count_q != '0 && cap_ok) begin
          srv_load      = 1'b1;
          wq_pop        = 1'b1;
          wait_count_d  = wait_count_q - WCW'(1);
          serve_count_d = serve_count_q + SCW'(1);
        end else begin
          emit_ev_d = EV_DISPATCH;
          emit_id_d = '0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic [31:0] wc32, sc32d;
  assign wc32  = 32'(wait_count_q);
  assign sc32d = 32'(serve_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      policy_q      <= '0;
      capacity_q    <= 4'd1;
      quantum_q     <= 16'd1;
      wait_count_q  <= '0;
      serve_count_q <= '0;
      held_count_q  <= '0;
      fin_cnt_q     <= '0;
      steps_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      wait_count_q  <= wait_count_d;
      serve_count_q <= serve_count_d;
      held_count_q  <= held_count_d;
      fin_cnt_q     <= fin_cnt_d;
      steps_q       <= steps_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY:   policy_q   <= cfg_data_i[1:0];
          CFG_CAPACITY: capacity_q <= cfg_data_i[3:0];
          CFG_QUANTUM:  quantum_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idle_q    <= idle_d;
    in_id_q   <= in_id_d;
    in_prio_q <= in_prio_d;
    in_time_q <= in_time_d;
    emit_ev_q <= emit_ev_d;
    emit_id_q <= emit_id_d;
    if (out_load) begin
      out_ev_q     <= out_ev_d;
      out_id_q     <= out_id_d;
      out_idle_q   <= out_idle_d;
      out_last_q   <= out_last_d;
      out_queued_q <= wc32[4:0];
      out_insvc_q  <= sc32d[3:0];
    end
  end

  ssjs_wait_row #(.QD(QUEUE_DEPTH), .TB(TIME_BITS)) u_wait (
    .clk_i      (clk_i),
    .prio_mode_i(policy_q == POL_PRIO),
    .count_i    (wait_count_q),
    .ins_i      (wq_ins),
    .pop_i      (wq_pop),
    .ins_data_i (wq_ins_data),
    .head_o     (wq_head)
  );

  ssjs_row #(.N(MAX_SERVERS), .W(SW)) u_srv (
    .clk_i      (clk_i),
    .shift_i    (srv_shift),
    .load_i     (srv_load),
    .load_idx_i (srv_idx),
    .load_data_i(srv_data),
    .head_o     (srv_head)
  );

  ssjs_row #(.N(MAX_SERVERS), .W(JW)) u_held (
    .clk_i      (clk_i),
    .shift_i    (held_shift),
    .load_i     (held_load),
    .load_idx_i (held_count_q[SIW-1:0]),
    .load_data_i({h_id, h_prio, t1}),
    .head_o     (held_head)
  );

  ssjs_row #(.N(MAX_SERVERS), .W(8)) u_fin (
    .clk_i      (clk_i),
    .shift_i    (fin_shift),
    .load_i     (fin_load),
    .load_idx_i (fin_cnt_q[SIW-1:0]),
    .load_data_i(h_id),
    .head_o     (fin_head)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, out_insvc_q, out_queued_q, out_idle_q, out_id_q};

endmodule

@@ test/tb_service_station_job_scheduler_core.sv @@
// Testbench for service_station_job_scheduler_core: drives random and directed
// requests, predicts result words with a scoreboard class. Depends on ssjs_pkg.
`timescale 1ns / 1ps

module tb_service_station_job_scheduler_core;
  import ssjs_pkg::*;

  localparam int QD = 16;
  localparam int MS = 8;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] id;
    logic       idl;
    logic [4:0] qn;
    logic [3:0] sn;
    logic       lst;
  } word_t;

  class sched_sb;
    logic [1:0]  pol;
    logic [3:0]  cap;
    logic [15:0] quant;
    logic [7:0]  w_id[QD];
    logic [7:0]  w_pr[QD];
    logic [15:0] w_t[QD];
    int          wn;
    logic [7:0]  s_id[MS];
    logic [7:0]  s_pr[MS];
    logic [15:0] s_t[MS];
    logic [15:0] s_sl[MS];
    int          sn;
    logic [7:0]  h_id[MS];
    logic [7:0]  h_pr[MS];
    logic [15:0] h_t[MS];
    int          hn;
    word_t       pending[$];
    int          errors;

    function new();
      pol = 0; cap = 1; quant = 1; wn = 0; sn = 0; hn = 0; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == CFG_POLICY) pol = v[1:0];
      else if (idx == CFG_CAPACITY) cap = v[3:0];
      else if (idx == CFG_QUANTUM) quant = v;
    endfunction

    function void push_word(logic [2:0] ev, logic [7:0] id, logic idl, logic lst);
      word_t w;
      w.ev = ev; w.id = id; w.idl = idl; w.qn = wn[4:0]; w.sn = sn[3:0]; w.lst = lst;
      pending.push_back(w);
    endfunction

    function void insert_job(logic [7:0] id, logic [7:0] pr, logic [15:0] t);
      int pos;
      pos = wn;
      if (pol == POL_PRIO)
        for (int i = 0; i < wn; i++)
          if (w_pr[i] < pr) begin
            pos = i;
            break;
          end
      for (int i = wn; i > pos; i--) begin
        w_id[i] = w_id[i-1]; w_pr[i] = w_pr[i-1]; w_t[i] = w_t[i-1];
      end
      w_id[pos] = id; w_pr[pos] = pr; w_t[pos] = t;
      wn++;
    endfunction

    function void note_request(logic [1:0] req, logic [7:0] id, logic [7:0] pr,
                               logic [15:0] t);
      int keep, k, first, c;
      logic idl, exp;
      case (req)
        REQ_ARRIVE: begin
          if (wn + hn >= QD) push_word(EV_REFUSED, id, 0, 1);
          else begin
            insert_job(id, pr, (t == 0) ? 16'd1 : t);
            push_word(EV_ACCEPTED, 0, 0, 1);
          end
        end
        REQ_TICK: begin
          idl = (sn == 0);
          keep = 0; k = 0; first = pending.size();
          for (int i = 0; i < sn; i++) begin
            exp = 0;
            s_t[i] = s_t[i] - 1;
            if (s_sl[i] != 0) begin
              s_sl[i]--;
              exp = (s_sl[i] == 0);
            end
            if (s_t[i] == 0) begin
              push_word(EV_FINISHED, s_id[i], 0, 0);
              k++;
              continue;
            end
            if (exp) begin
              if (hn < MS) begin
                h_id[hn] = s_id[i]; h_pr[hn] = s_pr[i]; h_t[hn] = s_t[i];
                hn++;
                continue;
              end
              s_sl[i] = quant;
            end
            s_id[keep] = s_id[i]; s_pr[keep] = s_pr[i];
            s_t[keep] = s_t[i]; s_sl[keep] = s_sl[i];
            keep++;
          end
          sn = keep;
          for (int i = first; i < first + k; i++) begin
            pending[i].sn = sn[3:0];
            pending[i].qn = wn[4:0];
          end
          push_word(EV_TICK, 0, idl, 1);
        end
        REQ_DISPATCH: begin
          c = (cap > MS) ? MS : cap;
          keep = 0;
          for (int i = 0; i < hn; i++) begin
            if (wn < QD) insert_job(h_id[i], h_pr[i], h_t[i]);
            else begin
              h_id[keep] = h_id[i]; h_pr[keep] = h_pr[i]; h_t[keep] = h_t[i];
              keep++;
            end
          end
          hn = keep;
          while (wn > 0 && sn < c) begin
            s_id[sn] = w_id[0]; s_pr[sn] = w_pr[0]; s_t[sn] = w_t[0];
            s_sl[sn] = (pol == POL_RR) ? quant : 16'd0;
            sn++;
            for (int i = 1; i < wn; i++) begin
              w_id[i-1] = w_id[i]; w_pr[i-1] = w_pr[i]; w_t[i-1] = w_t[i];
            end
            wn--;
          end
          push_word(EV_DISPATCH, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  sched_sb sb = new();
  bit      calm = 0;

  service_station_job_scheduler_core dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      w.ev = m_axis_tuser;
      w.id = m_axis_tdata[7:0];
      w.idl = m_axis_tdata[8];
      w.qn = m_axis_tdata[13:9];
      w.sn = m_axis_tdata[17:14];
      w.lst = m_axis_tlast;
      sb.check_word(w);
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);

  task automatic send_req(logic [1:0] req, logic [7:0] id, logic [7:0] pr,
                          logic [15:0] t);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= req;
    s_axis_tdata <= {t, pr, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(req, id, pr, t);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain_results();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    drain_results();
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50)
        send_req(REQ_ARRIVE, 8'($urandom), 8'($urandom),
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
      else if (r < 80) send_req(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
      else if (r < 97) send_req(REQ_DISPATCH, 8'($urandom), 8'($urandom), 16'($urandom));
      else send_req(2'd3, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: fill beyond depth, extremes, zero time, unknown request
    send_req(REQ_TICK, 8'd0, 8'd0, 16'd0);
    send_req(REQ_ARRIVE, 8'hff, 8'hff, 16'hffff);
    send_req(REQ_ARRIVE, 8'h00, 8'h00, 16'h0000);
    for (int i = 0; i < 15; i++) send_req(REQ_ARRIVE, 8'(i), 8'(i * 17), 16'd1);
    send_req(2'd3, 8'hff, 8'hff, 16'hffff);
    send_req(REQ_DISPATCH, 8'd0, 8'd0, 16'd0);
    send_req(REQ_TICK, 8'd0, 8'd0, 16'd0);
    write_reg(CFG_CAPACITY, 16'hffff);
    send_req(REQ_DISPATCH, 8'd0, 8'd0, 16'd0);
    send_req(REQ_TICK, 8'd0, 8'd0, 16'd0);
    send_req(REQ_TICK, 8'd0, 8'd0, 16'd0);
    drain_results();
    calm = 1;
    random_phase(20);
    calm = 0;
    write_reg(CFG_POLICY, 16'(POL_PRIO));
    write_reg(CFG_CAPACITY, 16'd3);
    random_phase(30);
    drain_results();
    write_reg(CFG_POLICY, 16'(POL_RR));
    write_reg(CFG_QUANTUM, 16'd1);
    write_reg(CFG_CAPACITY, 16'd8);
    random_phase(30);
    write_reg(CFG_QUANTUM, 16'hffff);
    write_reg(CFG_CAPACITY, 16'd0);
    random_phase(8);
    write_reg(CFG_POLICY, 16'd3);
    write_reg(CFG_QUANTUM, 16'd0);
    write_reg(CFG_CAPACITY, 16'd2);
    random_phase(18);
    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ service_station_job_scheduler_core.f @@
design/ssjs_pkg.sv
design/ssjs_cell.sv
design/ssjs_row.sv
design/ssjs_wait_row.sv
design/service_station_job_scheduler_core.sv
test/tb_service_station_job_scheduler_core.sv
